### src/cpr_pkg.sv
// Shared constants and types for the control page responder.
package cpr_pkg;

	// Operation codes of an incoming request.
	localparam logic OP_RX_PAGE = 1'b0;
	localparam logic OP_TX_SLOT = 1'b1;

	// Page numbers.
	localparam logic [7:0] PG_AVAIL   = 8'h02;
	localparam logic [7:0] PG_REQUEST = 8'h46;
	localparam logic [7:0] PG_STATUS  = 8'h47;
	localparam logic [7:0] PG_COMMAND = 8'h49;
	localparam logic [7:0] PG_MANUF   = 8'h50;
	localparam logic [7:0] PG_PRODUCT = 8'h51;

	// Transmit kinds.
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_AVAIL   = 3'd1;
	localparam logic [2:0] KIND_MANUF   = 3'd2;
	localparam logic [2:0] KIND_PRODUCT = 3'd3;
	localparam logic [2:0] KIND_STATUS  = 3'd4;

	// Slot counter values that are multiples of 130 and of 65 (not 130).
	localparam logic [7:0] SLOT_PRODUCT_A = 8'd0;
	localparam logic [7:0] SLOT_PRODUCT_B = 8'd130;
	localparam logic [7:0] SLOT_MANUF_A   = 8'd65;
	localparam logic [7:0] SLOT_MANUF_B   = 8'd195;

	// Reset values.
	localparam logic [7:0] CAPABILITY_RESET = 8'h10;
	localparam logic [7:0] NO_COMMAND       = 8'hFF;
	localparam logic [7:0] STATUS_PASS      = 8'h00;
	localparam logic [7:0] STATUS_UNINIT    = 8'hFF;

	// Queue control from the top level.
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] wdata;
	} fifo_ctl_t;

	// Queue status toward the top level.
	typedef struct packed {
		logic       empty;
		logic [7:0] head;
	} fifo_stat_t;

endpackage

### src/cpr_if.sv
// Request and response channel interfaces of the control page responder.
interface cpr_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [63:0] rx_payload;
	logic [7:0]  notify_flags;

	modport source (output valid, operation, rx_payload, notify_flags, input ready);
	modport sink (input valid, operation, rx_payload, notify_flags, output ready);
endinterface

interface cpr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  tx_kind;
	logic [63:0] tx_payload;
	logic        cmd_valid;
	logic [7:0]  cmd_sequence;
	logic [7:0]  cmd_code;
	logic [15:0] remote_serial;

	modport source (output valid, tx_kind, tx_payload, cmd_valid, cmd_sequence, cmd_code,
		remote_serial, input ready);
	modport sink (input valid, tx_kind, tx_payload, cmd_valid, cmd_sequence, cmd_code,
		remote_serial, output ready);
endinterface

### src/control_page_responder.sv
// Top level of the control page responder.
// A request moves on from the input register when the response register is free.
// Throughput: one request per cycle; the input register and the response register
// both advance whenever the response is taken or the response register is empty.
// Reset: arst_n empties the queue and clears the slot counter and valid flags at once;
// the command record resets to no command and the capability register to 0x10.
module control_page_responder
	import cpr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	cpr_in_if.sink          req_in,
	cpr_out_if.source       rsp_out
);

	logic        valid_s1;
	logic        op_s1;
	logic [63:0] rx_s1;
	logic [7:0]  notify_s1;

	logic [7:0]  capability_q;
	logic [7:0]  slot_cnt_q;
	logic [7:0]  last_cmd_q;
	logic [7:0]  last_seq_q;
	logic        status_pass_q;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [63:0] payload_q;
	logic        cmd_valid_q;
	logic [7:0]  cmd_seq_q;
	logic [7:0]  cmd_code_q;
	logic [15:0] serial_q;

	fifo_ctl_t   fifo_ctl;
	fifo_stat_t  fifo_stat;

	logic        out_free;
	logic        fire_s1;
	logic        is_rx;
	logic        is_new_cmd;
	logic        head_known;
	logic        sent_req;
	logic [7:0]  slot_next;
	logic [7:0]  status_byte;
	logic [2:0]  kind_d;
	logic [63:0] payload_d;

	// Both registers move when the output is free; the input register also when empty.
	assign out_free     = !out_valid_q || rsp_out.ready;
	assign fire_s1      = valid_s1 && out_free;
	assign req_in.ready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_in.ready) begin
			valid_s1 <= req_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_in.ready && req_in.valid) begin
			op_s1     <= req_in.operation;
			rx_s1     <= req_in.rx_payload;
			notify_s1 <= req_in.notify_flags;
		end
	end

	// Capability register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capability_q <= CAPABILITY_RESET;
		end else if (cfg_we) begin
			capability_q <= cfg_wdata;
		end
	end

	// Decode of the request in the input register.
	assign is_rx      = (op_s1 == OP_RX_PAGE);
	assign is_new_cmd = is_rx && (rx_s1[7:0] == PG_COMMAND) && (rx_s1[47:40] != last_seq_q);
	assign head_known = (fifo_stat.head == PG_MANUF) || (fifo_stat.head == PG_PRODUCT) ||
		(fifo_stat.head == PG_STATUS);
	assign sent_req   = !fifo_stat.empty && head_known;
	assign slot_next  = slot_cnt_q + 8'd1;
	assign status_byte = status_pass_q ? STATUS_PASS : STATUS_UNINIT;

	// Queue control.
	assign fifo_ctl.push  = fire_s1 && is_rx && (rx_s1[7:0] == PG_REQUEST);
	assign fifo_ctl.pop   = fire_s1 && !is_rx;
	assign fifo_ctl.wdata = rx_s1[55:48];

	cpr_req_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_req_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (fifo_ctl),
		.stat  (fifo_stat)
	);

	// Page selection for a transmit slot.
	always_comb begin
		kind_d    = KIND_NONE;
		payload_d = '0;
		if (!is_rx) begin
			if (sent_req) begin
				case (fifo_stat.head)
					PG_MANUF:   kind_d = KIND_MANUF;
					PG_PRODUCT: kind_d = KIND_PRODUCT;
					default: begin
						kind_d    = KIND_STATUS;
						payload_d = {32'd0, status_byte, last_seq_q, last_cmd_q, PG_STATUS};
					end
				endcase
			end else if ((slot_next == SLOT_PRODUCT_A) || (slot_next == SLOT_PRODUCT_B)) begin
				kind_d = KIND_PRODUCT;
			end else if ((slot_next == SLOT_MANUF_A) || (slot_next == SLOT_MANUF_B)) begin
				kind_d = KIND_MANUF;
			end else begin
				kind_d    = KIND_AVAIL;
				payload_d = {capability_q, 40'd0, notify_s1, PG_AVAIL};
			end
		end
	end

	// Slot counter and command record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q    <= '0;
			last_cmd_q    <= NO_COMMAND;
			last_seq_q    <= NO_COMMAND;
			status_pass_q <= 1'b0;
		end else if (fire_s1) begin
			if (!is_rx && !sent_req) begin
				slot_cnt_q <= slot_next;
			end
			if (is_new_cmd) begin
				last_cmd_q    <= rx_s1[55:48];
				last_seq_q    <= rx_s1[47:40];
				status_pass_q <= 1'b1;
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			kind_q      <= kind_d;
			payload_q   <= payload_d;
			cmd_valid_q <= is_new_cmd;
			cmd_seq_q   <= is_new_cmd ? rx_s1[47:40] : 8'd0;
			cmd_code_q  <= is_new_cmd ? rx_s1[55:48] : 8'd0;
			serial_q    <= is_new_cmd ? rx_s1[23:8] : 16'd0;
		end
	end

	assign rsp_out.valid         = out_valid_q;
	assign rsp_out.tx_kind       = kind_q;
	assign rsp_out.tx_payload    = payload_q;
	assign rsp_out.cmd_valid     = cmd_valid_q;
	assign rsp_out.cmd_sequence  = cmd_seq_q;
	assign rsp_out.cmd_code      = cmd_code_q;
	assign rsp_out.remote_serial = serial_q;

endmodule

### src/cpr_req_fifo.sv
// Page request queue with a registered head entry.
module cpr_req_fifo
	import cpr_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_ctl_t  ctl,
	output fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       head_q;
	logic [PTR_W-1:0] rd_ptr_next;
	logic [PTR_W-1:0] wr_ptr_next;
	logic             do_push;
	logic             do_pop;

	// A push into a full queue is dropped; a pop from an empty one does nothing.
	assign do_push = ctl.push && (count_q != FULL_CNT);
	assign do_pop  = ctl.pop && (count_q != '0);

	assign rd_ptr_next = do_pop ? ((rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
	assign wr_ptr_next = do_push ? ((wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1) : wr_ptr_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_next;
			wr_ptr_q <= wr_ptr_next;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= ctl.wdata;
		end
	end

	// Registered head read; a write to the next head address bypasses the array.
	always_ff @(posedge clk) begin
		if (do_push && (wr_ptr_q == rd_ptr_next)) begin
			head_q <= ctl.wdata;
		end else begin
			head_q <= mem[rd_ptr_next];
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.head  = head_q;

endmodule

### src/cpr_checker.sv
// Port-level checker for the control page responder and its bind.
module cpr_checker
	import cpr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  tx_kind,
	input logic [63:0] tx_payload,
	input logic        cmd_valid,
	input logic [7:0]  cmd_sequence,
	input logic [7:0]  cmd_code,
	input logic [15:0] remote_serial
);

	// A stalled response keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_payload) && $stable(tx_kind))
		else $error("response changed while stalled");

	// A command event comes only from a received page, which sends nothing.
	a_cmd_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_valid |-> tx_kind == KIND_NONE && tx_payload == 64'd0)
		else $error("command event with a transmit page");

	// Command fields are zero without a command event.
	a_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cmd_valid |->
		cmd_sequence == 8'd0 && cmd_code == 8'd0 && remote_serial == 16'd0)
		else $error("command fields set without an event");

	// Only availability and status pages carry payload bytes, each with its page number.
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(tx_kind == KIND_AVAIL && tx_payload[7:0] == PG_AVAIL) ||
		(tx_kind == KIND_STATUS && tx_payload[7:0] == PG_STATUS) ||
		(tx_payload == 64'd0 && (tx_kind == KIND_NONE || tx_kind == KIND_MANUF ||
		tx_kind == KIND_PRODUCT)))
		else $error("bad page kind or payload");

endmodule

bind control_page_responder cpr_checker u_cpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (rsp_out.valid),
	.out_ready    (rsp_out.ready),
	.tx_kind      (rsp_out.tx_kind),
	.tx_payload   (rsp_out.tx_payload),
	.cmd_valid    (rsp_out.cmd_valid),
	.cmd_sequence (rsp_out.cmd_sequence),
	.cmd_code     (rsp_out.cmd_code),
	.remote_serial(rsp_out.remote_serial)
);
